[hw/rtl/mlbc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the multi-channel LED blink controller.
package mlbc_pkg;

	localparam int NUM_LEDS  = 16;
	localparam int LED_IDX_W = $clog2(NUM_LEDS);
	localparam int LED_CNT_W = $clog2(NUM_LEDS + 1);

	typedef enum logic [2:0] {
		MODE_OFF     = 3'd0,
		MODE_ON      = 3'd1,
		MODE_SLOW    = 3'd2,
		MODE_MID     = 3'd3,
		MODE_FAST    = 3'd4,
		MODE_COUNTED = 3'd5,
		MODE_NONE    = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		CMD_TICK      = 2'd0,
		CMD_SET_MODE  = 2'd1,
		CMD_SET_BLINK = 2'd2,
		CMD_QUERY     = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_ACTIVE_COUNT = 3'd0,
		REG_INVERT_MASK  = 3'd1,
		REG_NOTIFY_MASK  = 3'd2,
		REG_SLOW_PERIOD  = 3'd3,
		REG_MID_PERIOD   = 3'd4,
		REG_FAST_PERIOD  = 3'd5
	} reg_idx_t;

	// One channel record as it is kept in the channel memory.
	typedef struct packed {
		mode_t       mode;
		logic [15:0] period;
		logic [7:0]  cycles_left;
		logic [15:0] wait_cnt;
	} chan_rec_t;

endpackage

[hw/rtl/mlbc_tick_unit.sv]
`timescale 1ns / 1ps
// Per-channel tick update: countdown, reload and blink action for one record.
module mlbc_tick_unit (
	input  mlbc_pkg::chan_rec_t rec,
	input  logic                on_now,
	input  logic                notify_en,
	output mlbc_pkg::chan_rec_t rec_next,
	output logic                on_next,
	output logic                fire
);

	always_comb begin
		rec_next = rec;
		on_next  = on_now;
		fire     = 1'b0;
		if (rec.wait_cnt > 16'd1) begin
			rec_next.wait_cnt = rec.wait_cnt - 16'd1;
		end else begin
			// The channel is due: reload the countdown in every mode.
			rec_next.wait_cnt = rec.period;
			case (rec.mode) inside
				mlbc_pkg::MODE_SLOW, mlbc_pkg::MODE_MID, mlbc_pkg::MODE_FAST: begin
					on_next = ~on_now;
					fire    = notify_en;
				end
				mlbc_pkg::MODE_COUNTED: begin
					if (rec.cycles_left != 8'd0) begin
						on_next = ~on_now;
						// A full on-off cycle ends when the toggle leaves the LED off.
						if (on_now) begin
							rec_next.cycles_left = rec.cycles_left - 8'd1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[hw/rtl/multi_led_blink_controller.sv]
`timescale 1ns / 1ps
// Top level of the multi-channel LED blink controller.
//
//   Channel   Handshake                 Payload
//   --------  ------------------------  ------------------------------------------------
//   command   start / busy              cmd, led_index, mode_value, blink_period,
//                                       blink_times
//   result    done (one-cycle strobe)   pin_levels, led_states, notify_fired,
//                                       selected_mode, selected_state
//   config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A command beat is taken when start is high and busy is low. A tick walks the
// active channels through the channel memory, which has one read port and one write
// port: one read per cycle with the update and write-back of the previous channel
// overlapped, then a read state and a write-back state follow before busy falls.
// Every other command, and a tick with no active channel, runs only those two states.
// The done strobe rises at the edge at which busy falls and lasts one cycle; the
// receiver cannot stall it.
// Reset clears the entry-written flags of the channel memory, so unwritten entries
// read as the reset record at once and no clearing pass is needed. The config port
// is always ready; registers are meant to be written while the block is idle.
module multi_led_blink_controller (
	input  logic        clk,
	input  logic        arst_n,
	// Command channel.
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [3:0]  led_index,
	input  logic [2:0]  mode_value,
	input  logic [15:0] blink_period,
	input  logic [7:0]  blink_times,
	// Result channel.
	output logic        done,
	output logic [15:0] pin_levels,
	output logic [15:0] led_states,
	output logic [15:0] notify_fired,
	output logic [2:0]  selected_mode,
	output logic        selected_state,
	// Configuration channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int IW = mlbc_pkg::LED_IDX_W;
	localparam int CW = mlbc_pkg::LED_CNT_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TICK,
		ST_SEL_RD,
		ST_SEL_WB
	} state_t;

	// Configuration registers.
	logic [4:0]  active_count_q;
	logic [15:0] invert_mask_q;
	logic [15:0] notify_mask_q;
	logic [15:0] slow_period_q;
	logic [15:0] mid_period_q;
	logic [15:0] fast_period_q;

	// Control and latched command.
	state_t                   state_q;
	logic [CW-1:0]            rd_cnt_q;
	mlbc_pkg::cmd_t           cmd_q;
	logic [IW-1:0]            idx_q;
	logic [2:0]               mode_val_q;
	logic [15:0]              bper_q;
	logic [7:0]               btimes_q;
	logic [mlbc_pkg::NUM_LEDS-1:0] on_q;
	logic [mlbc_pkg::NUM_LEDS-1:0] fired_q;
	logic [mlbc_pkg::NUM_LEDS-1:0] ent_vld_q;

	// Tick pipeline stage one: the channel whose read data is now available.
	logic          tick_vld_s1;
	logic [IW-1:0] tick_idx_s1;

	// Channel memory and its registered read port.
	mlbc_pkg::chan_rec_t chan_mem_q [mlbc_pkg::NUM_LEDS];
	mlbc_pkg::chan_rec_t rd_rec_s1;
	logic                rd_ent_vld_s1;

	// Result registers.
	logic        done_q;
	logic [15:0] pin_levels_q;
	logic [15:0] led_states_q;
	logic [15:0] notify_fired_q;
	logic [2:0]  selected_mode_q;
	logic        selected_state_q;

	// Combinational nets.
	logic [CW-1:0]       n_eff;
	logic                sel_ok;
	logic                rd_en;
	logic [IW-1:0]       rd_addr;
	mlbc_pkg::chan_rec_t rd_rec;
	mlbc_pkg::chan_rec_t tick_rec;
	logic                tick_on;
	logic                tick_fire;
	mlbc_pkg::chan_rec_t set_rec;
	logic                set_on;
	logic                set_we;
	mlbc_pkg::mode_t     req_mode;
	logic                wr_en;
	logic [IW-1:0]       wr_addr;
	mlbc_pkg::chan_rec_t wr_rec;
	logic [mlbc_pkg::NUM_LEDS-1:0] on_final;

	assign cfg_ready      = 1'b1;
	assign busy           = (state_q != ST_IDLE);
	assign done           = done_q;
	assign pin_levels     = pin_levels_q;
	assign led_states     = led_states_q;
	assign notify_fired   = notify_fired_q;
	assign selected_mode  = selected_mode_q;
	assign selected_state = selected_state_q;

	// Channels at or above the effective count are frozen and cannot be addressed.
	assign n_eff  = (active_count_q > CW'(mlbc_pkg::NUM_LEDS)) ?
		CW'(mlbc_pkg::NUM_LEDS) : CW'(active_count_q);
	assign sel_ok = (CW'(idx_q) < n_eff);

	// The tick walk owns the read port while it runs; afterwards the addressed
	// channel is read once for the set commands and the mode query.
	assign rd_en   = ((state_q == ST_TICK) && (rd_cnt_q < n_eff)) || (state_q == ST_SEL_RD);
	assign rd_addr = (state_q == ST_TICK) ? rd_cnt_q[IW-1:0] : idx_q;

	// An entry never written reads as the all-zero reset record (mode off, due now).
	assign rd_rec = rd_ent_vld_s1 ? rd_rec_s1 : '0;

	mlbc_tick_unit u_tick (
		.rec       (rd_rec),
		.on_now    (on_q[tick_idx_s1]),
		.notify_en (notify_mask_q[tick_idx_s1]),
		.rec_next  (tick_rec),
		.on_next   (tick_on),
		.fire      (tick_fire)
	);

	// Set commands modify the record that was just read for the addressed channel.
	always_comb begin
		req_mode = (mode_val_q > 3'(mlbc_pkg::MODE_FAST)) ?
			mlbc_pkg::MODE_FAST : mlbc_pkg::mode_t'(mode_val_q);
		set_rec = rd_rec;
		set_on  = on_q[idx_q];
		set_we  = 1'b0;
		case (cmd_q)
			mlbc_pkg::CMD_SET_MODE: begin
				set_we       = sel_ok;
				set_rec.mode = req_mode;
				case (req_mode)
					mlbc_pkg::MODE_SLOW: set_rec.period = slow_period_q;
					mlbc_pkg::MODE_MID:  set_rec.period = mid_period_q;
					mlbc_pkg::MODE_FAST: set_rec.period = fast_period_q;
					mlbc_pkg::MODE_ON:   set_on = 1'b1;
					default:             set_on = 1'b0;
				endcase
			end
			mlbc_pkg::CMD_SET_BLINK: begin
				set_we              = sel_ok;
				set_rec.period      = bper_q;
				set_rec.cycles_left = btimes_q;
				set_rec.mode        = mlbc_pkg::MODE_COUNTED;
			end
			default: begin
			end
		endcase
	end

	// The write port serves either the tick write-back or the set write.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_rec  = set_rec;
		if (tick_vld_s1) begin
			wr_en   = 1'b1;
			wr_addr = tick_idx_s1;
			wr_rec  = tick_rec;
		end else if ((state_q == ST_SEL_WB) && set_we) begin
			wr_en = 1'b1;
		end
	end

	always_comb begin
		on_final = on_q;
		if (set_we) begin
			on_final[idx_q] = set_on;
		end
	end

	// Channel memory: one write and one registered read per cycle. The tick walk
	// reads channel i while writing back channel i - 1, so the two never collide.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			chan_mem_q[wr_addr] <= wr_rec;
		end
		if (rd_en) begin
			rd_rec_s1     <= chan_mem_q[rd_addr];
			rd_ent_vld_s1 <= ent_vld_q[rd_addr] | (wr_en && (wr_addr == rd_addr));
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_count_q <= 5'd0;
			invert_mask_q  <= 16'd0;
			notify_mask_q  <= 16'd0;
			slow_period_q  <= 16'd1000;
			mid_period_q   <= 16'd500;
			fast_period_q  <= 16'd100;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mlbc_pkg::REG_ACTIVE_COUNT: active_count_q <= cfg_data[4:0];
				mlbc_pkg::REG_INVERT_MASK:  invert_mask_q  <= cfg_data;
				mlbc_pkg::REG_NOTIFY_MASK:  notify_mask_q  <= cfg_data;
				mlbc_pkg::REG_SLOW_PERIOD:  slow_period_q  <= cfg_data;
				mlbc_pkg::REG_MID_PERIOD:   mid_period_q   <= cfg_data;
				mlbc_pkg::REG_FAST_PERIOD:  fast_period_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer, channel on states and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			rd_cnt_q         <= '0;
			tick_vld_s1      <= 1'b0;
			tick_idx_s1      <= '0;
			on_q             <= '0;
			fired_q          <= '0;
			ent_vld_q        <= '0;
			done_q           <= 1'b0;
			cmd_q            <= mlbc_pkg::CMD_TICK;
			idx_q            <= '0;
			mode_val_q       <= '0;
			bper_q           <= '0;
			btimes_q         <= '0;
			pin_levels_q     <= '0;
			led_states_q     <= '0;
			notify_fired_q   <= '0;
			selected_mode_q  <= '0;
			selected_state_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (wr_en) begin
				ent_vld_q[wr_addr] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						cmd_q      <= mlbc_pkg::cmd_t'(cmd);
						idx_q      <= led_index;
						mode_val_q <= mode_value;
						bper_q     <= blink_period;
						btimes_q   <= blink_times;
						fired_q    <= '0;
						rd_cnt_q   <= '0;
						if ((mlbc_pkg::cmd_t'(cmd) == mlbc_pkg::CMD_TICK) &&
							(n_eff != '0)) begin
							state_q <= ST_TICK;
						end else begin
							state_q <= ST_SEL_RD;
						end
					end
				end
				ST_TICK: begin
					tick_vld_s1 <= rd_en;
					tick_idx_s1 <= rd_cnt_q[IW-1:0];
					if (rd_en) begin
						rd_cnt_q <= rd_cnt_q + CW'(1);
					end else begin
						// The last channel is written back at this edge.
						state_q <= ST_SEL_RD;
					end
					if (tick_vld_s1) begin
						on_q[tick_idx_s1] <= tick_on;
						if (tick_fire) begin
							fired_q[tick_idx_s1] <= 1'b1;
						end
					end
				end
				ST_SEL_RD: begin
					tick_vld_s1 <= 1'b0;
					state_q     <= ST_SEL_WB;
				end
				ST_SEL_WB: begin
					on_q             <= on_final;
					done_q           <= 1'b1;
					pin_levels_q     <= on_final ^ invert_mask_q;
					led_states_q     <= on_final;
					notify_fired_q   <= fired_q;
					selected_mode_q  <= sel_ok ? set_rec.mode : mlbc_pkg::MODE_NONE;
					selected_state_q <= sel_ok & on_final[idx_q];
					state_q          <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[bench/multi_led_blink_controller_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the multi-channel LED blink controller top level.
module multi_led_blink_controller_tb;

	localparam int CLK_PERIOD    = 20;
	localparam int RESET_CYCLES  = 7;
	// A tick holds busy only while it walks the channels and writes back the result,
	// and sender gaps are short geometric runs, so this leaves a wide margin.
	localparam int STALL_LIMIT   = 5000;
	localparam int RANDOM_ITEMS  = 1950;
	localparam int NUM_PHASES    = 6;
	// Quiet cycles after the last result before a register write or the end.
	localparam int SETTLE_CYCLES = 8;
	localparam int PRINT_LIMIT   = 100;

	// One result beat as it leaves the block.
	typedef struct packed {
		logic [15:0] pin_levels;
		logic [15:0] led_states;
		logic [15:0] notify_fired;
		logic [2:0]  selected_mode;
		logic        selected_state;
	} blink_result_t;

	// One row of the directed table: either a register write or a command beat,
	// optionally with the result typed in by hand.
	typedef struct {
		bit                 is_cfg;
		mlbc_pkg::reg_idx_t reg_sel;
		logic [15:0]        reg_val;
		mlbc_pkg::cmd_t     op;
		logic [3:0]         idx;
		logic [2:0]         mode_req;
		logic [15:0]        bper;
		logic [7:0]         btimes;
		bit                 typed;
		blink_result_t      want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  cmd;
	logic [3:0]  led_index;
	logic [2:0]  mode_value;
	logic [15:0] blink_period;
	logic [7:0]  blink_times;
	logic        done;
	logic [15:0] pin_levels;
	logic [15:0] led_states;
	logic [15:0] notify_fired;
	logic [2:0]  selected_mode;
	logic        selected_state;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	multi_led_blink_controller DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.cmd            (cmd),
		.led_index      (led_index),
		.mode_value     (mode_value),
		.blink_period   (blink_period),
		.blink_times    (blink_times),
		.done           (done),
		.pin_levels     (pin_levels),
		.led_states     (led_states),
		.notify_fired   (notify_fired),
		.selected_mode  (selected_mode),
		.selected_state (selected_state),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	// Shadow copy of the register file, kept in step with accepted writes.
	logic [4:0]  active_cfg;
	logic [15:0] invert_cfg;
	logic [15:0] notify_cfg;
	logic [15:0] slow_cfg;
	logic [15:0] mid_cfg;
	logic [15:0] fast_cfg;

	// Shadow copy of the per-channel records.
	mlbc_pkg::mode_t ch_mode   [mlbc_pkg::NUM_LEDS];
	logic            ch_on     [mlbc_pkg::NUM_LEDS];
	logic [15:0]     ch_period [mlbc_pkg::NUM_LEDS];
	logic [7:0]      ch_cycles [mlbc_pkg::NUM_LEDS];
	logic [15:0]     ch_wait   [mlbc_pkg::NUM_LEDS];

	// Results predicted for accepted command beats, oldest first.
	blink_result_t expected_results[$];
	stim_row_t     directed_rows[$];

	// The driver hands a hand-typed result to the monitor along with the beat.
	bit            row_typed;
	blink_result_t row_want;

	int mismatches;
	int quiet_cycles;
	int idle_pct;

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Writes one register in the shadow copy, exactly as the block should.
	function automatic void apply_register(mlbc_pkg::reg_idx_t sel, logic [15:0] val);
		case (sel)
			mlbc_pkg::REG_ACTIVE_COUNT: active_cfg = val[4:0];
			mlbc_pkg::REG_INVERT_MASK:  invert_cfg = val;
			mlbc_pkg::REG_NOTIFY_MASK:  notify_cfg = val;
			mlbc_pkg::REG_SLOW_PERIOD:  slow_cfg   = val;
			mlbc_pkg::REG_MID_PERIOD:   mid_cfg    = val;
			mlbc_pkg::REG_FAST_PERIOD:  fast_cfg   = val;
			default: ;
		endcase
	endfunction

	// Applies one command beat to the shadow channel records and returns the
	// result beat that the block must produce for it.
	function automatic blink_result_t predict_blinker(mlbc_pkg::cmd_t op, logic [3:0] idx,
			logic [2:0] mode_req, logic [15:0] bper, logic [7:0] btimes);
		blink_result_t res;
		int unsigned   n;
		int            i;
		bit            valid;
		logic [2:0]    clamped;
		// Counts above the channel total behave as the channel total.
		n = (active_cfg < mlbc_pkg::NUM_LEDS) ? active_cfg : mlbc_pkg::NUM_LEDS;
		valid = (idx < n);
		res = '0;
		case (op)
			mlbc_pkg::CMD_TICK: begin
				for (i = 0; i < n; i++) begin
					if (ch_wait[i] > 16'd1) begin
						ch_wait[i] = ch_wait[i] - 16'd1;
					end else begin
						// Due: reload in every mode, then act on the mode.
						ch_wait[i] = ch_period[i];
						case (ch_mode[i])
							mlbc_pkg::MODE_SLOW, mlbc_pkg::MODE_MID,
							mlbc_pkg::MODE_FAST: begin
								ch_on[i] = ~ch_on[i];
								if (notify_cfg[i]) begin
									res.notify_fired[i] = 1'b1;
								end
							end
							mlbc_pkg::MODE_COUNTED: begin
								// One on-off cycle is used up when a toggle ends off.
								if (ch_cycles[i] != 8'd0) begin
									ch_on[i] = ~ch_on[i];
									if (!ch_on[i]) begin
										ch_cycles[i] = ch_cycles[i] - 8'd1;
									end
								end
							end
							default: ;
						endcase
					end
				end
			end
			mlbc_pkg::CMD_SET_MODE: begin
				if (valid) begin
					clamped = (mode_req > mlbc_pkg::MODE_FAST) ? mlbc_pkg::MODE_FAST
						: mode_req;
					ch_mode[idx] = mlbc_pkg::mode_t'(clamped);
					case (ch_mode[idx])
						mlbc_pkg::MODE_SLOW: ch_period[idx] = slow_cfg;
						mlbc_pkg::MODE_MID:  ch_period[idx] = mid_cfg;
						mlbc_pkg::MODE_FAST: ch_period[idx] = fast_cfg;
						mlbc_pkg::MODE_ON:   ch_on[idx] = 1'b1;
						default:             ch_on[idx] = 1'b0;
					endcase
				end
			end
			mlbc_pkg::CMD_SET_BLINK: begin
				if (valid) begin
					ch_period[idx] = bper;
					ch_cycles[idx] = btimes;
					ch_mode[idx]   = mlbc_pkg::MODE_COUNTED;
				end
			end
			default: ;
		endcase
		// Inactive channels are frozen but still show up in the pin and state words.
		for (i = 0; i < mlbc_pkg::NUM_LEDS; i++) begin
			res.led_states[i] = ch_on[i];
			res.pin_levels[i] = ch_on[i] ^ invert_cfg[i];
		end
		res.selected_mode  = valid ? ch_mode[idx] : mlbc_pkg::MODE_NONE;
		res.selected_state = valid ? ch_on[idx] : 1'b0;
		return res;
	endfunction

	task automatic note_mismatch(string what, logic [15:0] got, logic [15:0] want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT) begin
			$display("%0t ns: %s: got 0x%04h, expected 0x%04h", $time, what, got, want);
		end
	endtask

	function automatic void add_row(mlbc_pkg::cmd_t op, logic [3:0] idx,
			logic [2:0] mode_req, logic [15:0] bper, logic [7:0] btimes,
			bit typed = 1'b0, blink_result_t want = '0);
		stim_row_t row;
		row = '{is_cfg: 1'b0, reg_sel: mlbc_pkg::REG_ACTIVE_COUNT, reg_val: '0, op: op,
			idx: idx, mode_req: mode_req, bper: bper, btimes: btimes, typed: typed,
			want: want};
		directed_rows.push_back(row);
	endfunction

	function automatic void add_cfg(mlbc_pkg::reg_idx_t sel, logic [15:0] val);
		stim_row_t row;
		row = '{is_cfg: 1'b1, reg_sel: sel, reg_val: val, op: mlbc_pkg::CMD_QUERY,
			idx: '0, mode_req: '0, bper: '0, btimes: '0, typed: 1'b0, want: '0};
		directed_rows.push_back(row);
	endfunction

	// Random period: mostly a few ticks so blinking shows up, now and then the
	// largest or any value so every bit of the register is used.
	function automatic logic [15:0] pick_period();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 85) begin
			return 16'($urandom_range(0, 6));
		end else if (roll < 92) begin
			return 16'hFFFF;
		end
		return 16'($urandom_range(0, 65535));
	endfunction

	// Called at a falling edge. Idles the command side at random, then holds the
	// beat until it is taken. Returns at the falling edge after acceptance with
	// start still high, so a following beat can go out without a bubble.
	task automatic offer_item(mlbc_pkg::cmd_t op, logic [3:0] idx, logic [2:0] mode_req,
			logic [15:0] bper, logic [7:0] btimes, bit typed, blink_result_t want);
		while ($urandom_range(0, 99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		cmd          = op;
		led_index    = idx;
		mode_value   = mode_req;
		blink_period = bper;
		blink_times  = btimes;
		row_typed    = typed;
		row_want     = want;
		start        = 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// Drops start and waits until every predicted result has come back, then waits
	// out the settle time so the block is surely back at rest.
	task automatic wait_idle();
		start = 1'b0;
		while (expected_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Called at a falling edge with the block idle. Leaves cfg_valid high so that
	// back-to-back writes do not drop it between beats.
	task automatic write_register(mlbc_pkg::reg_idx_t sel, logic [15:0] val);
		cfg_index = sel;
		cfg_data  = val;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic load_settings(logic [4:0] active, logic [15:0] inv, logic [15:0] ntf,
			logic [15:0] slow, logic [15:0] mid, logic [15:0] fast);
		wait_idle();
		write_register(mlbc_pkg::REG_ACTIVE_COUNT, {11'd0, active});
		write_register(mlbc_pkg::REG_INVERT_MASK, inv);
		write_register(mlbc_pkg::REG_NOTIFY_MASK, ntf);
		write_register(mlbc_pkg::REG_SLOW_PERIOD, slow);
		write_register(mlbc_pkg::REG_MID_PERIOD, mid);
		write_register(mlbc_pkg::REG_FAST_PERIOD, fast);
		cfg_valid = 1'b0;
	endtask

	// Monitor and scoreboard. Everything is sampled at the rising edge; the
	// driver only moves inputs at the falling edge, so no race can arise.
	always @(posedge clk) begin
		blink_result_t got;
		blink_result_t want;
		blink_result_t model;
		bit            progress;
		if (arst_n) begin
			progress = 1'b0;
			// A result strobe is checked before a beat taken at the same edge is
			// queued, so the oldest expectation is always the one compared.
			if (done === 1'b1) begin
				progress = 1'b1;
				got = {pin_levels, led_states, notify_fired, selected_mode, selected_state};
				if (expected_results.size() == 0) begin
					note_mismatch("result beat with nothing expected, pin_levels",
						got.pin_levels, 16'd0);
				end else begin
					want = expected_results.pop_front();
					if (got.pin_levels !== want.pin_levels) begin
						note_mismatch("pin_levels", got.pin_levels, want.pin_levels);
					end
					if (got.led_states !== want.led_states) begin
						note_mismatch("led_states", got.led_states, want.led_states);
					end
					if (got.notify_fired !== want.notify_fired) begin
						note_mismatch("notify_fired", got.notify_fired, want.notify_fired);
					end
					if (got.selected_mode !== want.selected_mode) begin
						note_mismatch("selected_mode", {13'd0, got.selected_mode},
							{13'd0, want.selected_mode});
					end
					if (got.selected_state !== want.selected_state) begin
						note_mismatch("selected_state", {15'd0, got.selected_state},
							{15'd0, want.selected_state});
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				progress = 1'b1;
				apply_register(mlbc_pkg::reg_idx_t'(cfg_index), cfg_data);
			end
			if (start && !busy) begin
				progress = 1'b1;
				// The shadow state always advances; a hand-typed row replaces
				// only the predicted value that goes into the queue.
				model = predict_blinker(mlbc_pkg::cmd_t'(cmd), led_index, mode_value,
					blink_period, blink_times);
				expected_results.push_back(row_typed ? row_want : model);
			end
			// Watchdog: a long run of cycles with no beat of any kind means a hang.
			if (progress) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", STALL_LIMIT);
				$display("multi_led_blink_controller: mismatch");
				$finish;
			end
		end
	end

	initial begin
		int             phase;
		int             item;
		int             roll;
		int             waited;
		mlbc_pkg::cmd_t op;
		logic [4:0]     active;
		logic [15:0]    bper;
		logic [7:0]     btimes;

		// Every input is known from time zero, and the shadow state matches reset.
		arst_n       = 1'b0;
		start        = 1'b0;
		cmd          = mlbc_pkg::CMD_TICK;
		led_index    = '0;
		mode_value   = '0;
		blink_period = '0;
		blink_times  = '0;
		cfg_valid    = 1'b0;
		cfg_index    = mlbc_pkg::REG_ACTIVE_COUNT;
		cfg_data     = '0;
		row_typed    = 1'b0;
		row_want     = '0;
		mismatches   = 0;
		quiet_cycles = 0;
		idle_pct     = 0;
		active_cfg   = '0;
		invert_cfg   = '0;
		notify_cfg   = '0;
		slow_cfg     = 16'd1000;
		mid_cfg      = 16'd500;
		fast_cfg     = 16'd100;
		for (int i = 0; i < mlbc_pkg::NUM_LEDS; i++) begin
			ch_mode[i]   = mlbc_pkg::MODE_OFF;
			ch_on[i]     = 1'b0;
			ch_period[i] = '0;
			ch_cycles[i] = '0;
			ch_wait[i]   = '0;
		end

		// Directed table. Straight after reset no channel is active, so every
		// command is ignored and the addressed channel reads as not present.
		add_row(mlbc_pkg::CMD_TICK, 4'd0, mlbc_pkg::MODE_OFF, 16'd0, 8'd0, 1'b1,
			{16'h0000, 16'h0000, 16'h0000, mlbc_pkg::MODE_NONE, 1'b0});
		add_row(mlbc_pkg::CMD_SET_MODE, 4'd0, mlbc_pkg::MODE_ON, 16'd0, 8'd0, 1'b1,
			{16'h0000, 16'h0000, 16'h0000, mlbc_pkg::MODE_NONE, 1'b0});
		add_row(mlbc_pkg::CMD_QUERY, 4'd15, 3'd7, 16'hFFFF, 8'hFF, 1'b1,
			{16'h0000, 16'h0000, 16'h0000, mlbc_pkg::MODE_NONE, 1'b0});
		// All channels active with very short blink periods.
		add_cfg(mlbc_pkg::REG_ACTIVE_COUNT, 16'd16);
		add_cfg(mlbc_pkg::REG_NOTIFY_MASK, 16'hFFFF);
		add_cfg(mlbc_pkg::REG_SLOW_PERIOD, 16'd3);
		add_cfg(mlbc_pkg::REG_MID_PERIOD, 16'd2);
		add_cfg(mlbc_pkg::REG_FAST_PERIOD, 16'd1);
		// Highest channel forced on and off.
		add_row(mlbc_pkg::CMD_SET_MODE, 4'd15, mlbc_pkg::MODE_ON, 16'd0, 8'd0, 1'b1,
			{16'h8000, 16'h8000, 16'h0000, mlbc_pkg::MODE_ON, 1'b1});
		add_row(mlbc_pkg::CMD_SET_MODE, 4'd15, mlbc_pkg::MODE_OFF, 16'd0, 8'd0, 1'b1,
			{16'h0000, 16'h0000, 16'h0000, mlbc_pkg::MODE_OFF, 1'b0});
		// Out-of-range modes clamp to fast blink.
		add_row(mlbc_pkg::CMD_SET_MODE, 4'd0, 3'd7, 16'd0, 8'd0, 1'b1,
			{16'h0000, 16'h0000, 16'h0000, mlbc_pkg::MODE_FAST, 1'b0});
		add_row(mlbc_pkg::CMD_SET_MODE, 4'd1, 3'd5, 16'd0, 8'd0, 1'b1,
			{16'h0000, 16'h0000, 16'h0000, mlbc_pkg::MODE_FAST, 1'b0});
		add_row(mlbc_pkg::CMD_SET_MODE, 4'd2, mlbc_pkg::MODE_SLOW, 16'd0, 8'd0);
		add_row(mlbc_pkg::CMD_SET_MODE, 4'd3, mlbc_pkg::MODE_MID, 16'd0, 8'd0);
		// Counted blink: zero period, largest period, zero count, a short run.
		add_row(mlbc_pkg::CMD_SET_BLINK, 4'd4, mlbc_pkg::MODE_OFF, 16'd0, 8'hFF, 1'b1,
			{16'h0000, 16'h0000, 16'h0000, mlbc_pkg::MODE_COUNTED, 1'b0});
		add_row(mlbc_pkg::CMD_SET_BLINK, 4'd5, mlbc_pkg::MODE_OFF, 16'hFFFF, 8'd1, 1'b1,
			{16'h0000, 16'h0000, 16'h0000, mlbc_pkg::MODE_COUNTED, 1'b0});
		add_row(mlbc_pkg::CMD_SET_BLINK, 4'd6, mlbc_pkg::MODE_OFF, 16'd1, 8'd0);
		add_row(mlbc_pkg::CMD_SET_BLINK, 4'd7, mlbc_pkg::MODE_OFF, 16'd2, 8'd2);
		for (int t = 0; t < 6; t++) begin
			add_row(mlbc_pkg::CMD_TICK, 4'(t + 2), mlbc_pkg::MODE_OFF, 16'd0, 8'd0);
		end
		add_row(mlbc_pkg::CMD_QUERY, 4'd4, 3'd7, 16'hFFFF, 8'hFF);
		// Only four channels active, all pins active low: the upper channels are
		// frozen but still visible, and commands to them are dropped.
		add_cfg(mlbc_pkg::REG_ACTIVE_COUNT, 16'd4);
		add_cfg(mlbc_pkg::REG_INVERT_MASK, 16'hFFFF);
		add_row(mlbc_pkg::CMD_QUERY, 4'd15, mlbc_pkg::MODE_OFF, 16'd0, 8'd0);
		add_row(mlbc_pkg::CMD_SET_MODE, 4'd10, mlbc_pkg::MODE_ON, 16'd0, 8'd0);
		add_row(mlbc_pkg::CMD_TICK, 4'd3, mlbc_pkg::MODE_OFF, 16'd0, 8'd0);
		add_row(mlbc_pkg::CMD_SET_BLINK, 4'd3, mlbc_pkg::MODE_OFF, 16'd0, 8'd1);
		add_row(mlbc_pkg::CMD_TICK, 4'd3, mlbc_pkg::MODE_OFF, 16'd0, 8'd0);

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		idle_pct = 23;
		foreach (directed_rows[r]) begin
			if (directed_rows[r].is_cfg) begin
				wait_idle();
				write_register(directed_rows[r].reg_sel, directed_rows[r].reg_val);
				cfg_valid = 1'b0;
			end else begin
				offer_item(directed_rows[r].op, directed_rows[r].idx,
					directed_rows[r].mode_req, directed_rows[r].bper,
					directed_rows[r].btimes, directed_rows[r].typed,
					directed_rows[r].want);
			end
		end

		// Random part. Each phase drains the block, loads new settings and runs
		// with its own sender idling. The first three phases pin the extremes.
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: load_settings(5'd16, 16'($urandom_range(0, 65535)), 16'hFFFF,
					16'd3, 16'd2, 16'd1);
				1: load_settings(5'd31, 16'h0000, 16'h0000, 16'd0, 16'hFFFF, 16'd0);
				2: load_settings(5'd1, 16'hFFFF, 16'h0001, 16'd2, 16'd1, 16'd65535);
				default: begin
					active = ($urandom_range(0, 99) < 60) ? 5'd16 : 5'($urandom_range(0, 31));
					load_settings(active, 16'($urandom_range(0, 65535)),
						16'($urandom_range(0, 65535)), pick_period(), pick_period(),
						pick_period());
				end
			endcase
			// Phases alternate between no idling, heavy idling and light idling.
			case (phase % 3)
				0:       idle_pct = 0;
				1:       idle_pct = 56;
				default: idle_pct = 23;
			endcase
			for (item = 0; item < RANDOM_ITEMS / NUM_PHASES; item++) begin
				// Ticks dominate so that blinking and counted runs play out.
				roll = $urandom_range(0, 99);
				if (roll < 50) begin
					op = mlbc_pkg::CMD_TICK;
				end else if (roll < 70) begin
					op = mlbc_pkg::CMD_SET_MODE;
				end else if (roll < 90) begin
					op = mlbc_pkg::CMD_SET_BLINK;
				end else begin
					op = mlbc_pkg::CMD_QUERY;
				end
				bper   = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 6))
					: 16'($urandom_range(0, 65535));
				btimes = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, 4))
					: 8'($urandom_range(0, 255));
				offer_item(op, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
					bper, btimes, 1'b0, '0);
			end
		end

		// Drain, with a bound of its own, then let the block settle.
		start = 1'b0;
		waited = 0;
		while (expected_results.size() != 0 && waited < STALL_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (expected_results.size() != 0) begin
			note_mismatch("result beats never arrived", 16'(expected_results.size()), 16'd0);
		end
		if (mismatches == 0) begin
			$display("multi_led_blink_controller: match");
		end else begin
			$display("multi_led_blink_controller: mismatch");
		end
		$finish;
	end

endmodule

[multi_led_blink_controller.f]
hw/rtl/mlbc_pkg.sv
hw/rtl/mlbc_tick_unit.sv
hw/rtl/multi_led_blink_controller.sv
bench/multi_led_blink_controller_tb.sv
